FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, result codes and the structs that run between the
// queue core and its storage cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned TAG_WIDTH_DEF = 16;
  localparam int unsigned PRICE_W       = 32;
  localparam int unsigned STATUS_W      = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Request broadcast to every cell.
  typedef struct packed {
    logic                      ins;
    logic                      rem_shift;
    logic signed [PRICE_W-1:0] price;
  } cell_cmd_t;

  // Per-cell compare results, seen by the neighbors and the core.
  typedef struct packed {
    logic lt;
    logic eq;
    logic ge;
    logic first_eq;
    logic last;
  } cell_flags_t;

endpackage

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue storage cell
// Holds one entry, compares it with the request price and takes the new
// entry or a neighbor's entry when the row opens or closes a slot.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned TAG_WIDTH = 16,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned IDX       = 0
) (
  input  logic                              clk,
  input  spq_pkg::cell_cmd_t                cmd,
  input  logic [TAG_WIDTH-1:0]              cmd_tag,
  input  logic [CNT_W-1:0]                  count,
  input  spq_pkg::cell_flags_t              prev_flags,
  input  logic signed [spq_pkg::PRICE_W-1:0] prev_price,
  input  logic [TAG_WIDTH-1:0]              prev_tag,
  input  logic signed [spq_pkg::PRICE_W-1:0] next_price,
  input  logic [TAG_WIDTH-1:0]              next_tag,
  output spq_pkg::cell_flags_t              flags,
  output logic signed [spq_pkg::PRICE_W-1:0] price,
  output logic [TAG_WIDTH-1:0]              tag
);
  import spq_pkg::*;

  logic signed [PRICE_W-1:0] price_r, price_nxt;
  logic [TAG_WIDTH-1:0]      tag_r, tag_nxt;
  logic                      valid;
  logic                      below;
  logic                      same;

  assign valid = (CNT_W'(IDX) < count);
  assign below = (price_r < cmd.price);
  assign same  = (price_r == cmd.price);

  always_comb begin
    flags.lt       = valid && (below || ((IDX == 0) && same));
    flags.eq       = valid && same;
    flags.ge       = !below;
    flags.first_eq = valid && same && !prev_flags.eq;
    flags.last     = valid && (CNT_W'(IDX + 1) == count);
  end

  always_comb begin
    price_nxt = price_r;
    tag_nxt   = tag_r;
    priority if (cmd.ins && !flags.lt && prev_flags.lt) begin
      price_nxt = cmd.price;
      tag_nxt   = cmd_tag;
    end else if (cmd.ins && !flags.lt) begin
      price_nxt = prev_price;
      tag_nxt   = prev_tag;
    end else if (cmd.rem_shift && flags.ge) begin
      price_nxt = next_price;
      tag_nxt   = next_tag;
    end else begin
      price_nxt = price_r;
      tag_nxt   = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    tag_r   <= tag_nxt;
  end

  assign price = price_r;
  assign tag   = tag_r;

endmodule

FILE: sv/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// The result strobe rises in the cycle after the request transfer.
// Throughput: one request per cycle; busy stays low, since every cell
// compares and shifts in the same cycle and no request waits on another.
// Reset clears the fill count and the result strobe; entry storage is not
// cleared and needs no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
  parameter int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic signed [spq_pkg::PRICE_W-1:0] in_price,
  input  logic [TAG_WIDTH-1:0]               in_tag,
  output logic                               out_valid,
  output logic [spq_pkg::STATUS_W-1:0]       out_status,
  output logic [TAG_WIDTH-1:0]               out_removed_tag,
  output logic [CNT_W-1:0]                   out_fill_count,
  output logic signed [spq_pkg::PRICE_W-1:0] out_head_price,
  output logic [TAG_WIDTH-1:0]               out_head_tag
);
  import spq_pkg::*;

  cell_flags_t               flags_a [DEPTH];
  logic signed [PRICE_W-1:0] price_a [DEPTH];
  logic [TAG_WIDTH-1:0]      tag_a   [DEPTH];
  cell_cmd_t                 cmd;

  logic                      accept;
  logic                      full;
  logic                      ins_ok;
  logic                      rem_ok;
  logic                      any_eq;
  logic                      last_eq;
  logic                      tail_case;
  logic [TAG_WIDTH-1:0]      first_tag;
  logic [TAG_WIDTH-1:0]      last_tag;
  logic [TAG_WIDTH-1:0]      rem_tag;
  status_t                   status_nxt;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [TAG_WIDTH-1:0]      out_removed_tag_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));

  always_comb begin
    any_eq    = 1'b0;
    last_eq   = 1'b0;
    first_tag = '0;
    last_tag  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_eq  = any_eq | flags_a[i].eq;
      last_eq = last_eq | (flags_a[i].eq & flags_a[i].last);
      if (flags_a[i].first_eq) begin
        first_tag = first_tag | tag_a[i];
      end
      if (flags_a[i].last) begin
        last_tag = last_tag | tag_a[i];
      end
    end
  end

  assign tail_case = !flags_a[0].eq && last_eq;
  assign ins_ok    = accept && (in_req_type == REQ_INSERT) && !full;
  assign rem_ok    = accept && (in_req_type == REQ_REMOVE) && any_eq;
  assign rem_tag   = tail_case ? last_tag : first_tag;

  always_comb begin
    cmd.ins       = ins_ok;
    cmd.rem_shift = rem_ok && !tail_case;
    cmd.price     = in_price;
  end

  always_comb begin
    count_nxt = count_r;
    priority if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    status_nxt = ST_DONE;
    priority if (in_req_type == REQ_INSERT && full) begin
      status_nxt = ST_FULL;
    end else if (in_req_type == REQ_REMOVE && !any_eq) begin
      status_nxt = ST_NOT_FOUND;
    end else begin
      status_nxt = ST_DONE;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_flags_t               prev_flags;
    logic signed [PRICE_W-1:0] prev_price;
    logic [TAG_WIDTH-1:0]      prev_tag;
    logic signed [PRICE_W-1:0] next_price;
    logic [TAG_WIDTH-1:0]      next_tag;

    if (g == 0) begin : g_head
      assign prev_flags = '{lt: 1'b1, eq: 1'b0, ge: 1'b0, first_eq: 1'b0, last: 1'b0};
      assign prev_price = in_price;
      assign prev_tag   = in_tag;
    end else begin : g_body
      assign prev_flags = flags_a[g-1];
      assign prev_price = price_a[g-1];
      assign prev_tag   = tag_a[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_price = price_a[g];
      assign next_tag   = tag_a[g];
    end else begin : g_inner
      assign next_price = price_a[g+1];
      assign next_tag   = tag_a[g+1];
    end

    spq_cell #(
      .TAG_WIDTH (TAG_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cmd_tag    (in_tag),
      .count      (count_r),
      .prev_flags (prev_flags),
      .prev_price (prev_price),
      .prev_tag   (prev_tag),
      .next_price (next_price),
      .next_tag   (next_tag),
      .flags      (flags_a[g]),
      .price      (price_a[g]),
      .tag        (tag_a[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r      <= status_nxt;
      out_removed_tag_r <= rem_ok ? rem_tag : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_removed_tag = out_removed_tag_r;
  assign out_fill_count  = count_r;
  assign out_head_price  = (count_r != '0) ? price_a[0] : '0;
  assign out_head_tag    = (count_r != '0) ? tag_a[0] : '0;

endmodule

FILE: sv/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the top-level ports for result timing and result consistency.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
  parameter int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [spq_pkg::STATUS_W-1:0]       out_status,
  input logic [TAG_WIDTH-1:0]               out_removed_tag,
  input logic [CNT_W-1:0]                   out_fill_count,
  input logic signed [spq_pkg::PRICE_W-1:0] out_head_price,
  input logic [TAG_WIDTH-1:0]               out_head_tag
);
  import spq_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("A request transfer was not followed by a result.");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("A result appeared without a request transfer.");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fill_count == '0) |-> (out_head_price == '0 && out_head_tag == '0))
    else $error("An empty queue reported a nonzero head.");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_fill_count == CNT_W'(DEPTH)))
    else $error("A dropped insert was reported while the queue was not full.");

  a_tag_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_removed_tag == '0))
    else $error("A failed request reported a removed tag.");

endmodule

bind sorted_priority_queue_core spq_checker #(
  .DEPTH     (DEPTH),
  .TAG_WIDTH (TAG_WIDTH),
  .CNT_W     (CNT_W)
) u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_removed_tag (out_removed_tag),
  .out_fill_count  (out_fill_count),
  .out_head_price  (out_head_price),
  .out_head_tag    (out_head_tag)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Sends insert and remove-by-price requests through the start/busy port.
// A model of the ordered entry store in the bench predicts every result.
// Each strobed result is checked field by field against the oldest
// prediction. Directed cases cover the empty queue and a single entry.
// They also cover full-range prices, duplicate keys, the full queue and
// removal at the head, the tail and the middle. Random traffic follows in
// phases with different sender gap rates. It swings the fill level between
// empty and full, and most removes name a price that is stored.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned TAG_W        = TAG_WIDTH_DEF;
  localparam int unsigned CNT_W        = $clog2(DEPTH_DEF + 1);
  localparam realtime     CLK_PERIOD   = 12.0;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    status_t                   status;
    logic [TAG_W-1:0]          removed_tag;
    logic [CNT_W-1:0]          fill_count;
    logic signed [PRICE_W-1:0] head_price;
    logic [TAG_W-1:0]          head_tag;
  } queue_outcome_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_req_type = REQ_INSERT;
  logic signed [PRICE_W-1:0] in_price = '0;
  logic [TAG_W-1:0]          in_tag = '0;
  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic [TAG_W-1:0]          out_removed_tag;
  logic [CNT_W-1:0]          out_fill_count;
  logic signed [PRICE_W-1:0] out_head_price;
  logic [TAG_W-1:0]          out_head_tag;

  logic signed [PRICE_W-1:0] book_price [DEPTH];
  logic [TAG_W-1:0]          book_tag [DEPTH];
  int unsigned               book_count = 0;
  bit                        book_growing = 1'b1;

  queue_outcome_t outcome_fifo [$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;

  sorted_priority_queue_core #(
    .DEPTH    (DEPTH),
    .TAG_WIDTH(TAG_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_price       (in_price),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_removed_tag(out_removed_tag),
    .out_fill_count (out_fill_count),
    .out_head_price (out_head_price),
    .out_head_tag   (out_head_tag)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic queue_outcome_t predict_order_book(input logic req,
                                                        input logic signed [PRICE_W-1:0] price,
                                                        input logic [TAG_W-1:0] tag);
    queue_outcome_t res;
    int             pos;
    bit             found;
    res.status      = ST_DONE;
    res.removed_tag = '0;
    found           = 1'b0;
    pos             = 0;
    if (req == REQ_INSERT) begin
      if (book_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        if (book_count == 0 || price < book_price[0]) begin
          pos = 0;
        end else if (price > book_price[book_count-1]) begin
          pos = book_count;
        end else begin
          pos = 1;
          while (pos < book_count && book_price[pos] < price) pos++;
        end
        for (int i = book_count; i > pos; i--) begin
          book_price[i] = book_price[i-1];
          book_tag[i]   = book_tag[i-1];
        end
        book_price[pos] = price;
        book_tag[pos]   = tag;
        book_count++;
      end
    end else begin
      if (book_count > 0) begin
        if (book_price[0] == price) begin
          found = 1'b1;
        end else if (book_price[book_count-1] == price) begin
          pos   = book_count - 1;
          found = 1'b1;
        end else begin
          for (int i = 1; i < book_count && !found; i++) begin
            if (book_price[i] == price) begin
              pos   = i;
              found = 1'b1;
            end
          end
        end
      end
      if (found) begin
        res.removed_tag = book_tag[pos];
        for (int i = pos; i + 1 < book_count; i++) begin
          book_price[i] = book_price[i+1];
          book_tag[i]   = book_tag[i+1];
        end
        book_count--;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.fill_count = book_count[CNT_W-1:0];
    res.head_price = (book_count > 0) ? book_price[0] : '0;
    res.head_tag   = (book_count > 0) ? book_tag[0] : '0;
    return res;
  endfunction

  task automatic send_request(input logic req, input logic signed [PRICE_W-1:0] price,
                              input logic [TAG_W-1:0] tag);
    start       <= 1'b1;
    in_req_type <= req;
    in_price    <= price;
    in_tag      <= tag;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    outcome_fifo.push_back(predict_order_book(req, price, tag));
  endtask

  task automatic hold_off(input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string field, input longint expv, input longint actv);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0d, actual %0d", $realtime, field, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    queue_outcome_t exp_res;
    if (out_valid === 1'b1) begin
      if (outcome_fifo.size() == 0) begin
        report_mismatch("unexpected transfer, status", -1, out_status);
      end else begin
        exp_res = outcome_fifo.pop_front();
        if (out_status !== exp_res.status)
          report_mismatch("status", exp_res.status, out_status);
        if (out_removed_tag !== exp_res.removed_tag)
          report_mismatch("removed_tag", exp_res.removed_tag, out_removed_tag);
        if (out_fill_count !== exp_res.fill_count)
          report_mismatch("fill_count", exp_res.fill_count, out_fill_count);
        if (out_head_price !== exp_res.head_price)
          report_mismatch("head_price", exp_res.head_price, out_head_price);
        if (out_head_tag !== exp_res.head_tag)
          report_mismatch("head_tag", exp_res.head_tag, out_head_tag);
      end
    end
  end

  function automatic logic signed [PRICE_W-1:0] pick_price(input bit for_remove);
    int unsigned sel;
    sel = $urandom_range(99);
    if (for_remove && book_count > 0 && sel < 75) begin
      return book_price[$urandom_range(book_count - 1)];
    end
    sel = $urandom_range(99);
    if (sel < 45) begin
      return int'($urandom_range(12)) - 6;
    end else if (sel < 70 && book_count > 0) begin
      return book_price[$urandom_range(book_count - 1)];
    end else if (sel < 75) begin
      return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end
    return $urandom;
  endfunction

  task automatic test_empty_and_single();
    send_request(REQ_REMOVE, 32'sd0, 16'h0000);
    send_request(REQ_INSERT, 32'sd5, 16'h0001);
    send_request(REQ_INSERT, 32'sd5, 16'h0002);
    send_request(REQ_REMOVE, 32'sd5, 16'hFFFF);
    send_request(REQ_REMOVE, 32'sd5, 16'h0000);
  endtask

  task automatic test_fill_to_full();
    send_request(REQ_INSERT, 32'sd100, 16'hFFFF);
    send_request(REQ_INSERT, 32'sh8000_0000, 16'h0000);
    send_request(REQ_INSERT, 32'sh7FFF_FFFF, 16'h0001);
    send_request(REQ_INSERT, 32'sd50, 16'h5555);
    send_request(REQ_INSERT, 32'sd100, 16'hAAAA);
    send_request(REQ_INSERT, 32'sh7FFF_FFFF, 16'h0006);
    send_request(REQ_INSERT, 32'sh8000_0000, 16'h0007);
    send_request(REQ_INSERT, 32'sd0, 16'h0008);
    send_request(REQ_INSERT, -32'sd1, 16'h0009);
    send_request(REQ_INSERT, 32'sd1, 16'h000A);
    send_request(REQ_INSERT, 32'sh5555_5555, 16'h000B);
    send_request(REQ_INSERT, 32'shAAAA_AAAA, 16'h000C);
    send_request(REQ_INSERT, 32'sd7, 16'h000D);
    send_request(REQ_INSERT, 32'sd7, 16'h000E);
    send_request(REQ_INSERT, -32'sd100, 16'h000F);
    send_request(REQ_INSERT, 32'sd3, 16'h0010);
    send_request(REQ_INSERT, 32'sd9, 16'h0011);
    send_request(REQ_REMOVE, 32'sh8000_0000, 16'h0000);
    send_request(REQ_REMOVE, 32'sh7FFF_FFFF, 16'h0000);
    send_request(REQ_REMOVE, 32'sd7, 16'h0000);
    send_request(REQ_REMOVE, 32'sd12345, 16'h0000);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct);
    logic req;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (book_count >= DEPTH) book_growing = 1'b0;
      else if (book_count == 0) book_growing = 1'b1;
      else if ($urandom_range(99) < 3) book_growing = ~book_growing;
      req = ($urandom_range(99) < (book_growing ? 75 : 25)) ? REQ_INSERT : REQ_REMOVE;
      hold_off(idle_pct);
      send_request(req, pick_price(req == REQ_REMOVE), TAG_W'($urandom));
    end
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    @(posedge clk);
    while (outcome_fifo.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_single();
    test_fill_to_full();
    test_random_traffic(200, 0);
    test_random_traffic(200, 76);
    test_drain_pause();
    test_random_traffic(250, 14);
    start <= 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
sv/spq_checker.sv
dv/tb_top.sv
